[rtl/tlg_pkg.sv]
// Shared constants for the toroidal life generation block and its checker.
package tlg_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int SIZE_W   = 9;
  localparam int COORD_W  = 8;
  localparam int OPCODE_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W  = 4;

  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [SIZE_W-1:0] MIN_SIZE   = 9'd4;
  localparam int                SIZE_RESET = 256;

  localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

endpackage

[rtl/tlg_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
module tlg_ram #(
  parameter int WIDTH  = 1,
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/toroidal_life_generation.sv]
// Top level of the toroidal Conway life engine with two cell banks.
// A write, an unused opcode or an out-of-range access gives its result in the cycle after
// the accepting edge; an in-range read first passes through the read state.
// A step reads three cells per column position, (W+2) positions per row, through the
// single read port of the bank. One item is worked on at a time; busy stays high while
// an in-range read or a step is in progress.
// Reset (synchronous, active high) makes bank a active and sets both sizes to their
// maximum; the cell banks themselves are not cleared and hold nothing until written.
module toroidal_life_generation #(
  parameter int MAX_WIDTH  = tlg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tlg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic [tlg_pkg::OPCODE_W-1:0]   opcode,
  input  logic [tlg_pkg::COORD_W-1:0]    cell_x,
  input  logic [tlg_pkg::COORD_W-1:0]    cell_y,
  input  logic                           write_value,
  output logic                           cell_value,
  output logic [tlg_pkg::OPCODE_W-1:0]   completed_opcode,
  output logic                           out_of_range,
  input  logic                           cfg_write,
  input  logic [tlg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlg_pkg::SIZE_W-1:0]     cfg_data
);

  localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(CELLS);
  localparam int SW     = tlg_pkg::SIZE_W;
  localparam int KW     = SW + 1;
  localparam int WIDTH_RESET  = (MAX_WIDTH  < tlg_pkg::SIZE_RESET) ? MAX_WIDTH
                                                                    : tlg_pkg::SIZE_RESET;
  localparam int HEIGHT_RESET = (MAX_HEIGHT < tlg_pkg::SIZE_RESET) ? MAX_HEIGHT
                                                                    : tlg_pkg::SIZE_RESET;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP
  } state_t;

  state_t state;

  // Configuration registers and the bank flag.
  logic [SW-1:0] grid_width;
  logic [SW-1:0] grid_height;
  logic          bank_a_active;

  // Read issue counters of a step: row, column position and which of the three rows.
  logic          iss_active;
  logic [SW-1:0] iss_row;
  logic [KW-1:0] iss_k;
  logic [1:0]    iss_r;

  // Tags that travel alongside the read data, registered together with the read address.
  logic          tag_valid;
  logic [SW-1:0] tag_row;
  logic [KW-1:0] tag_k;
  logic [1:0]    tag_r;

  // Column being gathered and the 3 by 3 window; bit 0 is the row above, bit 2 below.
  logic [1:0] col_buf;
  logic [2:0] win_l;
  logic [2:0] win_m;
  logic [2:0] win_r;

  logic          eval_valid;
  logic [SW-1:0] eval_row;
  logic [KW-1:0] eval_x;

  logic          accept;
  logic          in_range;
  logic [AW-1:0] cell_addr;
  logic [SW-1:0] row_up;
  logic [SW-1:0] row_down;
  logic [SW-1:0] rd_row;
  logic [KW-1:0] rd_col;
  logic [KW-1:0] last_k;
  logic [AW-1:0] step_raddr;
  logic [AW-1:0] step_waddr;
  logic [AW-1:0] raddr;
  logic [tlg_pkg::COUNT_W-1:0] neighbours;
  logic          next_alive;
  logic          op_we;
  logic          we_a;
  logic          we_b;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic          rdata_a;
  logic          rdata_b;
  logic          rdata;
  logic [SW-1:0] cfg_clamped;
  logic [SW-1:0] cfg_limit;

  function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] row,
                                            input logic [KW-1:0] col);
    addr_of = AW'(AW'(row) * AW'(MAX_WIDTH)) + AW'(col);
  endfunction

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign in_range  = ({1'b0, cell_x} < grid_width) && ({1'b0, cell_y} < grid_height);
  assign cell_addr = addr_of(SW'(cell_y), KW'(cell_x));

  // Torus neighbours of the current row, and the column for the current position:
  // position 0 fetches the last column, the final position wraps back to column 0.
  assign row_up   = (iss_row == '0) ? grid_height - SW'(1) : iss_row - SW'(1);
  assign row_down = (iss_row == grid_height - SW'(1)) ? '0 : iss_row + SW'(1);
  assign last_k   = KW'(grid_width) + KW'(1);

  always_comb begin
    case (iss_r)
      2'd0:    rd_row = row_up;
      2'd1:    rd_row = iss_row;
      default: rd_row = row_down;
    endcase
    if (iss_k == '0) begin
      rd_col = KW'(grid_width) - KW'(1);
    end else if (iss_k == last_k) begin
      rd_col = '0;
    end else begin
      rd_col = iss_k - KW'(1);
    end
  end

  assign step_raddr = addr_of(rd_row, rd_col);
  assign step_waddr = addr_of(eval_row, eval_x);
  assign raddr      = (state == ST_STEP) ? step_raddr : cell_addr;

  // B3/S23 rule on the window that was completed in the previous cycle.
  assign neighbours = tlg_pkg::COUNT_W'(win_l[0]) + tlg_pkg::COUNT_W'(win_l[1])
                    + tlg_pkg::COUNT_W'(win_l[2]) + tlg_pkg::COUNT_W'(win_m[0])
                    + tlg_pkg::COUNT_W'(win_m[2]) + tlg_pkg::COUNT_W'(win_r[0])
                    + tlg_pkg::COUNT_W'(win_r[1]) + tlg_pkg::COUNT_W'(win_r[2]);
  assign next_alive = (neighbours == tlg_pkg::BIRTH_COUNT)
                   || (win_m[1] && (neighbours == tlg_pkg::SURVIVE_COUNT));

  // Painting writes the active bank; a step writes the other one. Both never coincide.
  assign op_we = accept && (opcode == tlg_pkg::OP_WRITE) && in_range;
  assign we_a  = (op_we && bank_a_active) || (eval_valid && !bank_a_active);
  assign we_b  = (op_we && !bank_a_active) || (eval_valid && bank_a_active);
  assign waddr = eval_valid ? step_waddr : cell_addr;
  assign wdata = eval_valid ? next_alive : write_value;

  // The flag only changes once a step has drained, so it still names the bank that was
  // read in the cycle before.
  assign rdata = bank_a_active ? rdata_a : rdata_b;

  tlg_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_bank_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  tlg_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_bank_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  // Size writes saturate to the range that the banks can hold.
  assign cfg_limit = (cfg_index == tlg_pkg::REG_GRID_WIDTH) ? SW'(MAX_WIDTH)
                                                            : SW'(MAX_HEIGHT);
  always_comb begin
    if (cfg_data < tlg_pkg::MIN_SIZE) begin
      cfg_clamped = tlg_pkg::MIN_SIZE;
    end else if (((cfg_index == tlg_pkg::REG_GRID_WIDTH) && (32'(cfg_data) > MAX_WIDTH))
              || ((cfg_index != tlg_pkg::REG_GRID_WIDTH) && (32'(cfg_data) > MAX_HEIGHT)))
    begin
      cfg_clamped = cfg_limit;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_write && (cfg_index == tlg_pkg::REG_GRID_WIDTH)) begin
      grid_width <= cfg_clamped;
    end
    if (cfg_write && (cfg_index == tlg_pkg::REG_GRID_HEIGHT)) begin
      grid_height <= cfg_clamped;
    end
    if (rst) begin
      grid_width  <= SW'(WIDTH_RESET);
      grid_height <= SW'(HEIGHT_RESET);
    end
  end

  // Window datapath: gather the three rows of a column, then shift it in.
  always_ff @(posedge clk) begin
    if (tag_valid) begin
      case (tag_r)
        2'd0:    col_buf[0] <= rdata;
        2'd1:    col_buf[1] <= rdata;
        default: begin
          win_l <= win_m;
          win_m <= win_r;
          win_r <= {rdata, col_buf};
        end
      endcase
    end
    tag_row  <= iss_row;
    tag_k    <= iss_k;
    tag_r    <= iss_r;
    eval_row <= tag_row;
    eval_x   <= tag_k - KW'(2);
  end

  // Control: state, step sequencing and the registered result beat.
  always_ff @(posedge clk) begin
    done       <= 1'b0;
    tag_valid  <= iss_active;
    eval_valid <= tag_valid && (tag_r == 2'd2) && (tag_k >= KW'(2));
    case (state)
      ST_IDLE: begin
        if (accept) begin
          completed_opcode <= opcode;
          cell_value       <= 1'b0;
          out_of_range     <= 1'b0;
          case (opcode)
            tlg_pkg::OP_READ: begin
              if (in_range) begin
                state <= ST_READ;
              end else begin
                out_of_range <= 1'b1;
                done         <= 1'b1;
              end
            end
            tlg_pkg::OP_WRITE: begin
              out_of_range <= !in_range;
              done         <= 1'b1;
            end
            tlg_pkg::OP_STEP: begin
              state      <= ST_STEP;
              iss_active <= 1'b1;
              iss_row    <= '0;
              iss_k      <= '0;
              iss_r      <= '0;
            end
            default: begin
              done <= 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cell_value <= rdata;
        done       <= 1'b1;
        state      <= ST_IDLE;
      end
      ST_STEP: begin
        if (iss_active) begin
          if (iss_r != 2'd2) begin
            iss_r <= iss_r + 2'd1;
          end else begin
            iss_r <= '0;
            if (iss_k != last_k) begin
              iss_k <= iss_k + KW'(1);
            end else begin
              iss_k <= '0;
              if (iss_row == grid_height - SW'(1)) begin
                iss_active <= 1'b0;
              end else begin
                iss_row <= iss_row + SW'(1);
              end
            end
          end
        end else if (!tag_valid && !eval_valid) begin
          // Last write has landed: the new generation becomes the active bank.
          bank_a_active <= !bank_a_active;
          done          <= 1'b1;
          state         <= ST_IDLE;
        end
      end
      default: begin
        state <= ST_IDLE;
      end
    endcase
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      bank_a_active <= 1'b1;
      iss_active    <= 1'b0;
      tag_valid     <= 1'b0;
      eval_valid    <= 1'b0;
    end
  end

endmodule

[rtl/tlg_checker.sv]
// Port-level checker for the toroidal life generation block, with its bind.
module tlg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [tlg_pkg::OPCODE_W-1:0]  opcode,
  input logic                          cell_value,
  input logic [tlg_pkg::OPCODE_W-1:0]  completed_opcode,
  input logic                          out_of_range
);

  // Only a read beat may carry a live cell.
  assert property (@(posedge clk) disable iff (rst)
    done && cell_value |-> completed_opcode == tlg_pkg::OP_READ)
    else $error("cell_value set on a beat that answers no read");

  assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |->
      (completed_opcode == tlg_pkg::OP_READ) || (completed_opcode == tlg_pkg::OP_WRITE))
    else $error("out_of_range set on a beat that answers no cell access");

  // A read outside the grid answers at once; one inside it first stays busy in the read state.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == tlg_pkg::OP_READ |=>
      (done && !busy && out_of_range && completed_opcode == tlg_pkg::OP_READ) or
      (busy ##1 (done && completed_opcode == tlg_pkg::OP_READ)))
    else $error("read beat not delivered in time");

  assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode != tlg_pkg::OP_READ && opcode != tlg_pkg::OP_STEP |=>
      done && !busy && completed_opcode == $past(opcode))
    else $error("write beat not delivered in the next cycle");

  assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == tlg_pkg::OP_STEP |=> busy && !done)
    else $error("step finished without sweeping the grid");

endmodule

bind toroidal_life_generation tlg_checker u_tlg_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the toroidal life generation block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W     = tlg_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H     = tlg_pkg::DEF_MAX_HEIGHT;
  localparam int MAX_CELLS = MAX_W * MAX_H;

  // The package names only the opcodes and register indexes in use; the spare codes are
  // still driven, so they get names here.
  localparam logic [tlg_pkg::OPCODE_W-1:0]  OP_SPARE    = 2'd3;
  localparam logic [tlg_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [tlg_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // The slowest step here is on a 4 by 6 grid, and only a handful of them happen; the
  // limit leaves a wide margin over the whole run.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [tlg_pkg::OPCODE_W-1:0] op;
    logic [tlg_pkg::COORD_W-1:0]  x;
    logic [tlg_pkg::COORD_W-1:0]  y;
    logic                         v;
  } life_cmd_t;

  typedef struct packed {
    logic                         cell_value;
    logic [tlg_pkg::OPCODE_W-1:0] completed_opcode;
    logic                         out_of_range;
  } life_answer_t;

  logic                          clk;
  logic                          rst         = 1'b1;
  logic                          start       = 1'b0;
  logic [tlg_pkg::OPCODE_W-1:0]  opcode      = tlg_pkg::OP_WRITE;
  logic [tlg_pkg::COORD_W-1:0]   cell_x      = '0;
  logic [tlg_pkg::COORD_W-1:0]   cell_y      = '0;
  logic                          write_value = 1'b0;
  logic                          cfg_write   = 1'b0;
  logic [tlg_pkg::CFG_IDX_W-1:0] cfg_index   = tlg_pkg::REG_GRID_WIDTH;
  logic [tlg_pkg::SIZE_W-1:0]    cfg_data    = '0;
  logic                          busy;
  logic                          done;
  logic                          cell_value;
  logic [tlg_pkg::OPCODE_W-1:0]  completed_opcode;
  logic                          out_of_range;

  toroidal_life_generation uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .opcode           (opcode),
    .cell_x           (cell_x),
    .cell_y           (cell_y),
    .write_value      (write_value),
    .cell_value       (cell_value),
    .completed_opcode (completed_opcode),
    .out_of_range     (out_of_range),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Shadow copy of the engine. Bank a is index 0 and is in front after reset. The
  // written map records which cells have ever been loaded, so that no read and no
  // generation ever touches a cell whose contents are undefined.
  bit          life_bank [2][MAX_CELLS];
  bit          written   [2][MAX_CELLS];
  bit          front_bank = 1'b0;
  int unsigned grid_w     = tlg_pkg::SIZE_RESET;
  int unsigned grid_h     = tlg_pkg::SIZE_RESET;

  life_cmd_t    cmd_q[$];
  life_answer_t answer_q[$];
  life_cmd_t    cur_cmd;
  int unsigned  idle_pct    = 0;
  int unsigned  cycle_count = 0;
  int           error_count = 0;
  int           beats_in    = 0;
  int           beats_out   = 0;
  int           generations = 0;
  int           settings    = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned size_sat(logic [tlg_pkg::SIZE_W-1:0] raw,
                                           int unsigned hi);
    if (raw < tlg_pkg::MIN_SIZE) return tlg_pkg::MIN_SIZE;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic life_cmd_t mk_cmd(logic [tlg_pkg::OPCODE_W-1:0] op, int unsigned x,
                                       int unsigned y, bit v);
    life_cmd_t c;
    c.op = op;
    c.x  = x[tlg_pkg::COORD_W-1:0];
    c.y  = y[tlg_pkg::COORD_W-1:0];
    c.v  = v;
    return c;
  endfunction

  // Applies one accepted command to the shadow engine and returns the answer that the
  // block owes for it. A generation reads the front bank with wraparound on both axes,
  // fills the grid in use of the back bank and then swaps the banks.
  function automatic life_answer_t predict_answer(life_cmd_t c);
    life_answer_t ans;
    int unsigned  addr, gx, gy, nx, ny, live;
    int           dx, dy;
    bit           back;
    ans.cell_value       = 1'b0;
    ans.completed_opcode = c.op;
    ans.out_of_range     = 1'b0;
    if (c.op == tlg_pkg::OP_WRITE || c.op == tlg_pkg::OP_READ) begin
      if (c.x >= grid_w || c.y >= grid_h) begin
        ans.out_of_range = 1'b1;
      end else begin
        addr = c.y * MAX_W + c.x;
        if (c.op == tlg_pkg::OP_WRITE) begin
          life_bank[front_bank][addr] = c.v;
          written[front_bank][addr]   = 1'b1;
        end else begin
          ans.cell_value = life_bank[front_bank][addr];
        end
      end
    end else if (c.op == tlg_pkg::OP_STEP) begin
      back = ~front_bank;
      for (gy = 0; gy < grid_h; gy++) begin
        for (gx = 0; gx < grid_w; gx++) begin
          live = 0;
          for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
              if (dx != 0 || dy != 0) begin
                nx = (gx + grid_w + dx) % grid_w;
                ny = (gy + grid_h + dy) % grid_h;
                live += life_bank[front_bank][ny * MAX_W + nx];
              end
            end
          end
          addr = gy * MAX_W + gx;
          life_bank[back][addr] = (live == tlg_pkg::BIRTH_COUNT) ||
                                  (life_bank[front_bank][addr] &&
                                   live == tlg_pkg::SURVIVE_COUNT);
          written[back][addr]   = 1'b1;
        end
      end
      front_bank  = back;
      generations++;
    end
    return ans;
  endfunction

  // Command driver. A beat is taken at an edge that sees start high and busy low; the
  // prediction is made at that same edge, so that it sees the engine exactly as the
  // block does. A new command is offered only once the previous one has gone, and the
  // idle percentage decides whether this cycle is left empty instead.
  always @(posedge clk) begin : drive_commands
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        answer_q.push_back(predict_answer(cur_cmd));
        beats_in++;
      end
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          start       <= 1'b1;
          opcode      <= cur_cmd.op;
          cell_x      <= cur_cmd.x;
          cell_y      <= cur_cmd.y;
          write_value <= cur_cmd.v;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  // Result monitor. The block cannot be held off, so every strobed cycle is a result
  // beat and is matched against the oldest answer still owed.
  always @(posedge clk) begin : check_results
    life_answer_t want;
    if (!rst && done) begin
      beats_out++;
      if (answer_q.size() == 0) begin
        report_error($sformatf("result beat with nothing owed: value %0b op %0d oor %0b",
                               cell_value, completed_opcode, out_of_range));
      end else begin
        want = answer_q.pop_front();
        if (cell_value !== want.cell_value ||
            completed_opcode !== want.completed_opcode ||
            out_of_range !== want.out_of_range) begin
          report_error($sformatf(
            "result %0d: expected value %0b op %0d oor %0b, got value %0b op %0d oor %0b",
            beats_out, want.cell_value, want.completed_opcode, want.out_of_range,
            cell_value, completed_opcode, out_of_range));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles with %0d answers owed", cycle_count,
               answer_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One register write. The shadow sizes follow at once; the block is idle whenever this
  // runs, so no beat can be predicted against a stale size.
  task automatic write_reg(logic [tlg_pkg::CFG_IDX_W-1:0] idx,
                           logic [tlg_pkg::SIZE_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == tlg_pkg::REG_GRID_WIDTH) grid_w = size_sat(data, MAX_W);
    else if (idx == tlg_pkg::REG_GRID_HEIGHT) grid_h = size_sat(data, MAX_H);
  endtask

  // Waits until every command has gone in, every answer has come back and the block has
  // dropped busy. Sampled on the falling edge, where nothing is changing.
  task automatic settle();
    do @(negedge clk);
    while (cmd_q.size() != 0 || start || busy || answer_q.size() != 0);
  endtask

  // Loads random soup into every cell of the grid in use that the front bank has never
  // held. Cells left over from earlier, larger grids or earlier generations are kept, so
  // a grid that grows again shows whether a step really left them alone.
  task automatic paint_grid();
    int unsigned gx, gy;
    for (gy = 0; gy < grid_h; gy++)
      for (gx = 0; gx < grid_w; gx++)
        if (!written[front_bank][gy * MAX_W + gx])
          cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, gx, gy, $urandom_range(1)));
  endtask

  // Random traffic on a fully loaded grid: mostly writes and reads inside the grid, a
  // share of accesses beyond its edge, occasional generations and the spare opcode.
  task automatic queue_random(int n);
    int          i;
    int unsigned pick, rx, ry;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      rx   = $urandom_range(grid_w - 1);
      ry   = $urandom_range(grid_h - 1);
      if (pick < 38) begin
        cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, rx, ry, $urandom_range(1)));
      end else if (pick < 68 || (pick < 80 && grid_w == MAX_W && grid_h == MAX_H)) begin
        cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, rx, ry, $urandom_range(1)));
      end else if (pick < 80) begin
        if (grid_w < MAX_W && (grid_h == MAX_H || $urandom_range(1))) begin
          rx = $urandom_range(MAX_W - 1, grid_w);
          ry = $urandom_range(MAX_H - 1);
        end else begin
          rx = $urandom_range(MAX_W - 1);
          ry = $urandom_range(MAX_H - 1, grid_h);
        end
        cmd_q.push_back(mk_cmd($urandom_range(1) ? tlg_pkg::OP_READ : tlg_pkg::OP_WRITE,
                               rx, ry, $urandom_range(1)));
      end else if (pick < 93) begin
        cmd_q.push_back(mk_cmd(tlg_pkg::OP_STEP, $urandom_range(255), $urandom_range(255),
                               $urandom_range(1)));
      end else begin
        cmd_q.push_back(mk_cmd(OP_SPARE, $urandom_range(255), $urandom_range(255),
                               $urandom_range(1)));
      end
    end
  endtask

  // A full setting: new sizes, soup for any cell not yet held, an optional read of every
  // cell in the grid, random traffic, then a wait until the block is idle again.
  task automatic run_phase(logic [tlg_pkg::SIZE_W-1:0] wd, logic [tlg_pkg::SIZE_W-1:0] hd,
                           int unsigned idle, int n, bit sweep);
    int unsigned gx, gy;
    write_reg(tlg_pkg::REG_GRID_WIDTH, wd);
    write_reg(tlg_pkg::REG_GRID_HEIGHT, hd);
    @(negedge clk);
    idle_pct = idle;
    settings++;
    paint_grid();
    if (sweep)
      for (gy = 0; gy < grid_h; gy++)
        for (gx = 0; gx < grid_w; gx++)
          cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, gx, gy, 1'b0));
    queue_random(n);
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    settings = 1;

    // Reset sizes are the maximum, so the far corners must be in range. Only cells that
    // have just been written are read back.
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, 0, 0, 1'b1));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, 255, 0, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, 0, 255, 1'b1));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, 255, 255, 1'b1));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, 128, 127, 1'b1));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 0, 0, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 255, 0, 1'b1));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 0, 255, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 255, 255, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 128, 127, 1'b0));
    cmd_q.push_back(mk_cmd(OP_SPARE, 255, 255, 1'b1));
    cmd_q.push_back(mk_cmd(OP_SPARE, 0, 0, 1'b0));
    settle();

    // Sizes below the minimum saturate to four. The spare register indexes come after,
    // carrying values that would show if either were taken for a size.
    write_reg(tlg_pkg::REG_GRID_WIDTH, 9'd0);
    write_reg(tlg_pkg::REG_GRID_HEIGHT, 9'd3);
    write_reg(REG_SPARE_A, 9'd9);
    write_reg(REG_SPARE_B, 9'd7);
    @(negedge clk);
    settings++;
    paint_grid();

    // Accesses just past the edge and at the far end of the coordinate range touch
    // nothing. The corner written before is read back, and two generations on the
    // smallest torus make every neighbour wrap.
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, 4, 0, 1'b1));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 0, 4, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, 255, 255, 1'b1));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 4, 3, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 0, 0, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 3, 3, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_STEP, 0, 0, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 3, 0, 1'b0));
    cmd_q.push_back(mk_cmd(OP_SPARE, 3, 3, 1'b1));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_STEP, 255, 255, 1'b1));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 0, 3, 1'b0));
    queue_random(10);
    settle();

    // Sizes above the maximum saturate to it, so the far rows and columns are in range
    // again. Each cell is written before it is read.
    write_reg(tlg_pkg::REG_GRID_WIDTH, 9'd511);
    write_reg(tlg_pkg::REG_GRID_HEIGHT, 9'd300);
    @(negedge clk);
    settings++;
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, 255, 200, 1'b1));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 255, 200, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_WRITE, 200, 255, 1'b0));
    cmd_q.push_back(mk_cmd(tlg_pkg::OP_READ, 200, 255, 1'b1));
    settle();

    // Random settings. The last one is wider than the grid stepped before it and reads
    // every cell, so cells outside a stepped grid are checked.
    run_phase(9'd5, 9'd4, 80, 8, 1'b0);
    run_phase(9'd4, 9'd6, 22, 8, 1'b0);
    run_phase(9'd5, 9'd4, 0, 4, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (answer_q.size() != 0)
      report_error($sformatf("%0d answers never arrived", answer_q.size()));

    $display("Covered %0d command beats and %0d result beats over %0d grid settings,",
             beats_in, beats_out, settings);
    $display("including %0d generations on 4x4, 5x4 and 4x6 tori and saturated sizes.",
             generations);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tlg_pkg.sv
rtl/tlg_ram.sv
rtl/toroidal_life_generation.sv
rtl/tlg_checker.sv
tb/tb_top.sv
